// ----- hdl/assert_macros.svh -----
// assertion macros for the interval table, empty when synthesising
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SIT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("interval table assertion failed");

// next-cycle implication
`define SIT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("interval table assertion failed");

`else

`define SIT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SIT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- hdl/sit_pkg.sv -----
package sit_pkg;

	localparam int CAPACITY = 32;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CMP_W    = CNT_W + 1;

	localparam int TIME_W     = 11;
	localparam int ROOM_W     = 8;
	localparam int KIND_W     = 2;
	localparam int STATUS_W   = 3;
	localparam int OUT_IDX_W  = 5;
	localparam int CFG_W      = 11;
	localparam int CFG_ADDR_W = 1;

	localparam int ENTRY_W   = 2 * TIME_W + ROOM_W;
	localparam int RES_W     = STATUS_W + OUT_IDX_W + TIME_W + ROOM_W;
	localparam int S_TDATA_W = ((ENTRY_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;

	localparam logic [TIME_W-1:0] DAY_BEGIN_RST = TIME_W'(0);
	localparam logic [TIME_W-1:0] DAY_END_RST   = TIME_W'(1440);

	localparam logic [CFG_ADDR_W-1:0] REG_DAY_BEGIN = CFG_ADDR_W'(0);
	localparam logic [CFG_ADDR_W-1:0] REG_DAY_END   = CFG_ADDR_W'(1);

	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_FIND   = 2'd2
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK       = 3'd0,
		STAT_RANGE    = 3'd1,
		STAT_FULL     = 3'd2,
		STAT_EMPTY    = 3'd3,
		STAT_NOTFOUND = 3'd4
	} status_t;

	// begin in the low bits, then end, then room
	typedef struct packed {
		logic [ROOM_W-1:0] room;
		logic [TIME_W-1:0] fin;
		logic [TIME_W-1:0] bgn;
	} entry_t;

	// status in the low bits, then index, end, room
	typedef struct packed {
		logic [ROOM_W-1:0]    room;
		logic [TIME_W-1:0]    fin;
		logic [OUT_IDX_W-1:0] idx;
		status_t              status;
	} result_t;

endpackage

// ----- hdl/sorted_interval_table.sv -----
// insert: moves up each entry with a greater begin (at most CAPACITY - 1), then writes the new one
// find: binary search on begin, a ram read then a compare per probe; a rejected item
// goes straight to the result
// remove: the same search, then each entry above the hit is moved down
// throughput: one item at a time, set by the single read and write port of the entry ram
// reset: arst_n clears the entry count, day bounds (0, 1440) and the output valid
`include "assert_macros.svh"

module sorted_interval_table
	import sit_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]      cfg_wdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,   // begin_time, end_time, room
	input  logic [KIND_W-1:0]     s_tuser,   // kind
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata    // status, entry_index, found_end, found_room
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_SHIFT,
		S_INS_PUT,
		S_SRCH,
		S_SRCH_CMP,
		S_DEL_SHIFT,
		S_DONE
	} state_t;

	state_t            state_q;
	logic [TIME_W-1:0] day_begin_q;
	logic [TIME_W-1:0] day_end_q;
	logic [CNT_W-1:0]  cnt_q;
	kind_t             kind_q;
	entry_t            new_q;
	logic [IDX_W-1:0]  pos_q;
	logic [CNT_W-1:0]  lo_q;
	logic [CNT_W-1:0]  hix_q;    // one past the upper search bound
	logic [IDX_W-1:0]  mid_q;
	result_t           res_q;
	result_t           out_q;
	logic              out_valid_q;

	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [IDX_W-1:0] ram_raddr;
	entry_t           ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;
	entry_t           rd_e;

	entry_t           in_e;
	logic             accept;
	logic             bad_ins;
	logic             full;
	logic             ins_more;
	logic             srch_open;
	logic [CNT_W-1:0] half;
	logic [IDX_W-1:0] mid_idx;
	logic             out_free;

	assign in_e      = entry_t'(s_tdata[ENTRY_W-1:0]);
	assign rd_e      = entry_t'(ram_rdata);
	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign bad_ins   = (in_e.bgn < day_begin_q) || (in_e.fin > day_end_q)
		|| (in_e.bgn >= in_e.fin);
	assign full      = (cnt_q == CNT_W'(CAPACITY));
	assign ins_more  = (rd_e.bgn > new_q.bgn);
	assign srch_open = (lo_q < hix_q);
	assign half      = CNT_W'(hix_q - lo_q - CNT_W'(1)) >> 1;
	assign mid_idx   = IDX_W'(lo_q + half);
	assign out_free  = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = M_TDATA_W'(out_q);

	sit_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(CAPACITY)
	) u_entries (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// shifts write one slot while reading two slots away, so no address overlap
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = rd_e;
		ram_raddr = mid_idx;
		unique case (state_q)
			S_IDLE: begin
				ram_raddr = IDX_W'(cnt_q - CNT_W'(1));
			end
			S_INS_SHIFT: begin
				ram_we    = 1'b1;
				ram_raddr = pos_q - IDX_W'(2);
				if (!ins_more) begin
					ram_wdata = new_q;
				end
			end
			S_INS_PUT: begin
				ram_we    = 1'b1;
				ram_wdata = new_q;
			end
			S_SRCH: begin
				ram_raddr = mid_idx;
			end
			S_SRCH_CMP: begin
				ram_raddr = mid_q + IDX_W'(1);
			end
			S_DEL_SHIFT: begin
				ram_we    = 1'b1;
				ram_raddr = pos_q + IDX_W'(2);
			end
			S_DONE: begin
				ram_raddr = mid_idx;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			day_begin_q <= DAY_BEGIN_RST;
			day_end_q   <= DAY_END_RST;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_DAY_BEGIN: day_begin_q <= cfg_wdata;
					REG_DAY_END:   day_end_q   <= cfg_wdata;
					default:       day_end_q   <= day_end_q;
				endcase
			end

			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						new_q  <= in_e;
						kind_q <= kind_t'(s_tuser);
						res_q  <= '0;
						lo_q   <= '0;
						hix_q  <= cnt_q;
						case (kind_t'(s_tuser))
							KIND_INSERT: begin
								if (bad_ins) begin
									res_q.status <= STAT_RANGE;
									state_q      <= S_DONE;
								end else if (full) begin
									res_q.status <= STAT_FULL;
									state_q      <= S_DONE;
								end else if (cnt_q == '0) begin
									pos_q   <= '0;
									state_q <= S_INS_PUT;
								end else begin
									pos_q   <= IDX_W'(cnt_q);
									state_q <= S_INS_SHIFT;
								end
							end
							KIND_REMOVE: begin
								if (cnt_q == '0) begin
									res_q.status <= STAT_EMPTY;
									state_q      <= S_DONE;
								end else begin
									state_q <= S_SRCH;
								end
							end
							KIND_FIND: begin
								state_q <= S_SRCH;
							end
							default: begin
								res_q.status <= STAT_RANGE;
								state_q      <= S_DONE;
							end
						endcase
					end
				end
				S_INS_SHIFT: begin
					// read data is the entry just below pos_q
					if (ins_more) begin
						pos_q <= pos_q - IDX_W'(1);
						if (pos_q == IDX_W'(1)) begin
							state_q <= S_INS_PUT;
						end
					end else begin
						cnt_q   <= cnt_q + CNT_W'(1);
						state_q <= S_DONE;
					end
				end
				S_INS_PUT: begin
					cnt_q   <= cnt_q + CNT_W'(1);
					state_q <= S_DONE;
				end
				S_SRCH: begin
					if (srch_open) begin
						mid_q   <= mid_idx;
						state_q <= S_SRCH_CMP;
					end else begin
						res_q.status <= STAT_NOTFOUND;
						state_q      <= S_DONE;
					end
				end
				S_SRCH_CMP: begin
					if (rd_e.bgn == new_q.bgn) begin
						if (kind_q == KIND_FIND) begin
							res_q.idx  <= OUT_IDX_W'(mid_q);
							res_q.fin  <= rd_e.fin;
							res_q.room <= rd_e.room;
							state_q    <= S_DONE;
						end else begin
							pos_q <= mid_q;
							if ((CMP_W'(mid_q) + CMP_W'(1)) < CMP_W'(cnt_q)) begin
								state_q <= S_DEL_SHIFT;
							end else begin
								cnt_q   <= cnt_q - CNT_W'(1);
								state_q <= S_DONE;
							end
						end
					end else if (new_q.bgn > rd_e.bgn) begin
						lo_q    <= CNT_W'(CMP_W'(mid_q) + CMP_W'(1));
						state_q <= S_SRCH;
					end else begin
						hix_q   <= CNT_W'(mid_q);
						state_q <= S_SRCH;
					end
				end
				S_DEL_SHIFT: begin
					pos_q <= pos_q + IDX_W'(1);
					if (!((CMP_W'(pos_q) + CMP_W'(2)) < CMP_W'(cnt_q))) begin
						cnt_q   <= cnt_q - CNT_W'(1);
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_q   <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`SIT_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CNT_W'(CAPACITY))
	`SIT_ASSERT_NXT(a_one_item, clk, arst_n, s_tvalid && s_tready, !s_tready)
	`SIT_ASSERT_IMP(a_wr_busy, clk, arst_n, ram_we, (state_q == S_INS_SHIFT) || (state_q == S_INS_PUT) || (state_q == S_DEL_SHIFT))
	`SIT_ASSERT_IMP(a_cnt_step, clk, arst_n, !$stable(cnt_q), (cnt_q == CNT_W'($past(cnt_q) + 1'b1)) || (cnt_q == CNT_W'($past(cnt_q) - 1'b1)))

endmodule

// ----- hdl/sit_ram.sv -----
module sit_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- test/sorted_interval_table_test.sv -----
`timescale 1ns / 100ps

module sorted_interval_table_test;
	import sit_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;
	localparam int PHASE_ITEMS   = 382;
	localparam int SEGMENT_ITEMS = 64;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES   = 100;
	localparam int NUM_PHASES    = 4;
	localparam int NUM_ROWS      = 26;

	typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

	// for a register row, bgn holds the register index and fin the value
	typedef struct {
		row_kind_t         what;
		logic [KIND_W-1:0] kind;
		logic [TIME_W-1:0] bgn;
		logic [TIME_W-1:0] fin;
		logic [ROOM_W-1:0] room;
		bit                typed;
		status_t           status;
	} stim_row_t;

	stim_row_t directed_rows [NUM_ROWS] = '{
		'{ROW_ITEM, KIND_FIND,    100,  0,    0,   1, STAT_NOTFOUND},
		'{ROW_ITEM, KIND_REMOVE,  100,  0,    0,   1, STAT_EMPTY},
		'{ROW_ITEM, KIND_INSERT,  0,    1440, 255, 1, STAT_OK},
		'{ROW_ITEM, KIND_INSERT,  1440, 1440, 0,   1, STAT_RANGE},
		'{ROW_ITEM, KIND_INSERT,  10,   2047, 1,   1, STAT_RANGE},
		'{ROW_ITEM, KIND_INSERT,  500,  400,  2,   1, STAT_RANGE},
		'{ROW_ITEM, KIND_UNKNOWN, 2047, 2047, 255, 1, STAT_RANGE},
		'{ROW_ITEM, KIND_INSERT,  600,  700,  7,   1, STAT_OK},
		'{ROW_ITEM, KIND_INSERT,  600,  800,  8,   1, STAT_OK},
		'{ROW_ITEM, KIND_INSERT,  300,  400,  3,   1, STAT_OK},
		'{ROW_ITEM, KIND_INSERT,  1439, 1440, 0,   1, STAT_OK},
		'{ROW_ITEM, KIND_FIND,    0,    0,    0,   0, STAT_OK},
		'{ROW_ITEM, KIND_FIND,    600,  0,    0,   0, STAT_OK},
		'{ROW_ITEM, KIND_FIND,    2047, 2047, 255, 1, STAT_NOTFOUND},
		'{ROW_ITEM, KIND_REMOVE,  2047, 0,    0,   1, STAT_NOTFOUND},
		'{ROW_ITEM, KIND_REMOVE,  600,  0,    0,   1, STAT_OK},
		'{ROW_ITEM, KIND_FIND,    600,  0,    0,   0, STAT_OK},
		'{ROW_REG,  KIND_INSERT,  TIME_W'(REG_DAY_BEGIN), 100, 0, 0, STAT_OK},
		'{ROW_REG,  KIND_INSERT,  TIME_W'(REG_DAY_END),   200, 0, 0, STAT_OK},
		'{ROW_ITEM, KIND_INSERT,  99,   150,  9,   1, STAT_RANGE},
		'{ROW_ITEM, KIND_INSERT,  100,  200,  10,  1, STAT_OK},
		'{ROW_ITEM, KIND_INSERT,  100,  201,  11,  1, STAT_RANGE},
		// inverted day: nothing can be inserted
		'{ROW_REG,  KIND_INSERT,  TIME_W'(REG_DAY_BEGIN), 2047, 0, 0, STAT_OK},
		'{ROW_REG,  KIND_INSERT,  TIME_W'(REG_DAY_END),   0,    0, 0, STAT_OK},
		'{ROW_ITEM, KIND_INSERT,  0,    1,    0,   1, STAT_RANGE},
		'{ROW_ITEM, KIND_FIND,    100,  0,    0,   0, STAT_OK}
	};

	int phase_idle  [NUM_PHASES] = '{0, 78, 0, 33};
	int phase_stall [NUM_PHASES] = '{0, 0, 78, 33};
	int phase_lo    [NUM_PHASES] = '{0, 500, 0, 1000};
	int phase_hi    [NUM_PHASES] = '{2047, 900, 1440, 2047};

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
	logic [CFG_W-1:0]      cfg_wdata = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata   = '0;   // begin_time, end_time, room
	logic [KIND_W-1:0]     s_tuser   = '0;   // kind
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;          // status, entry_index, found_end, found_room

	// typed-in expectation travels alongside the item it belongs to
	bit      item_typed  = 1'b0;
	status_t item_status = STAT_OK;

	int idle_pct  = 0;
	int stall_pct = 0;
	bit hold_req  = 1'b0;
	int mismatch_count = 0;

	// own copy of the table and the day bounds
	logic [TIME_W-1:0] day_lo = DAY_BEGIN_RST;
	logic [TIME_W-1:0] day_hi = DAY_END_RST;
	logic [TIME_W-1:0] tbl_begin [CAPACITY];
	logic [TIME_W-1:0] tbl_end   [CAPACITY];
	logic [ROOM_W-1:0] tbl_room  [CAPACITY];
	int                tbl_count = 0;

	result_t result_q [$];
	result_t acc_res;
	result_t got_res;
	result_t want_res;
	entry_t  acc_item;

	sorted_interval_table u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// binary search on begin, first equal probe wins
	function automatic int table_search(input logic [TIME_W-1:0] key);
		int lo;
		int hi;
		int mid;
		lo = 0;
		hi = tbl_count - 1;
		while (lo <= hi) begin
			mid = lo + (hi - lo) / 2;
			if (key == tbl_begin[mid])
				return mid;
			if (key > tbl_begin[mid])
				lo = mid + 1;
			else
				hi = mid - 1;
		end
		return -1;
	endfunction

	function automatic result_t table_step(input logic [KIND_W-1:0] kind, input entry_t item);
		result_t res;
		int pos;
		int hit;
		int i;
		res = '0;
		res.status = STAT_OK;
		case (kind)
			KIND_INSERT: begin
				if (item.bgn < day_lo || item.fin > day_hi || item.bgn >= item.fin) begin
					res.status = STAT_RANGE;
				end else if (tbl_count >= CAPACITY) begin
					res.status = STAT_FULL;
				end else begin
					// equal begins stay in arrival order
					pos = tbl_count;
					while (pos > 0 && tbl_begin[pos - 1] > item.bgn) begin
						tbl_begin[pos] = tbl_begin[pos - 1];
						tbl_end[pos]   = tbl_end[pos - 1];
						tbl_room[pos]  = tbl_room[pos - 1];
						pos--;
					end
					tbl_begin[pos] = item.bgn;
					tbl_end[pos]   = item.fin;
					tbl_room[pos]  = item.room;
					tbl_count++;
				end
			end
			KIND_REMOVE: begin
				if (tbl_count == 0) begin
					res.status = STAT_EMPTY;
				end else begin
					hit = table_search(item.bgn);
					if (hit < 0) begin
						res.status = STAT_NOTFOUND;
					end else begin
						for (i = hit; i + 1 < tbl_count; i++) begin
							tbl_begin[i] = tbl_begin[i + 1];
							tbl_end[i]   = tbl_end[i + 1];
							tbl_room[i]  = tbl_room[i + 1];
						end
						tbl_count--;
					end
				end
			end
			KIND_FIND: begin
				hit = table_search(item.bgn);
				if (hit < 0) begin
					res.status = STAT_NOTFOUND;
				end else begin
					res.idx  = OUT_IDX_W'(hit);
					res.fin  = tbl_end[hit];
					res.room = tbl_room[hit];
				end
			end
			default: begin
				res.status = STAT_RANGE;
			end
		endcase
		return res;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_DAY_BEGIN: day_lo = cfg_wdata;
					REG_DAY_END:   day_hi = cfg_wdata;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				acc_item = s_tdata[ENTRY_W-1:0];
				acc_res = table_step(s_tuser, acc_item);
				if (item_typed) begin
					acc_res = '0;
					acc_res.status = item_status;
				end
				result_q.push_back(acc_res);
			end
			if (m_tvalid && m_tready) begin
				got_res = m_tdata[RES_W-1:0];
				if (result_q.size() == 0) begin
					$display("%0t: result with nothing expected, got status %0d idx %0d end %0d room %0d",
						$time, got_res.status, got_res.idx, got_res.fin, got_res.room);
					mismatch_count++;
				end else begin
					want_res = result_q.pop_front();
					if (got_res.status !== want_res.status || got_res.idx !== want_res.idx ||
							got_res.fin !== want_res.fin || got_res.room !== want_res.room) begin
						$display("%0t: expected status %0d idx %0d end %0d room %0d, got status %0d idx %0d end %0d room %0d",
							$time, want_res.status, want_res.idx, want_res.fin, want_res.room,
							got_res.status, got_res.idx, got_res.fin, got_res.room);
						mismatch_count++;
					end
				end
			end
		end
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic send_item(input logic [KIND_W-1:0] kind, input logic [TIME_W-1:0] bgn,
			input logic [TIME_W-1:0] fin, input logic [ROOM_W-1:0] room,
			input bit typed, input status_t status);
		entry_t ent;
		ent.bgn  = bgn;
		ent.fin  = fin;
		ent.room = room;
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid    <= 1'b1;
		s_tdata     <= S_TDATA_W'(ent);
		s_tuser     <= kind;
		item_typed  <= typed;
		item_status <= status;
		@(posedge clk iff s_tready);
	endtask

	// wait for a clock edge first so the last accepted item is already queued
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (result_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// filling segments lean on insert, draining ones on remove
	task automatic random_item(input bit filling);
		int pick;
		int ins_pct;
		int rem_pct;
		int lo;
		int hi;
		int b;
		logic [KIND_W-1:0] kind;
		logic [TIME_W-1:0] bgn;
		logic [TIME_W-1:0] fin;
		logic [ROOM_W-1:0] room;
		lo = int'(day_lo);
		hi = int'(day_hi);
		ins_pct = filling ? 70 : 5;
		rem_pct = filling ? 10 : 75;
		pick = $urandom_range(99);
		bgn  = TIME_W'($urandom_range(2047));
		fin  = TIME_W'($urandom_range(2047));
		room = ROOM_W'($urandom_range(255));
		if (pick < ins_pct) begin
			kind = KIND_INSERT;
			if (hi > lo && $urandom_range(9) != 0) begin
				// clustered begins give plenty of equal keys
				if ($urandom_range(1) == 0) begin
					b = lo + 8 * $urandom_range(7);
					if (b >= hi)
						b = lo;
				end else begin
					b = $urandom_range(hi - 1, lo);
				end
				bgn = TIME_W'(b);
				fin = TIME_W'($urandom_range(hi, b + 1));
			end
		end else if (pick < 95) begin
			kind = (pick < ins_pct + rem_pct) ? KIND_REMOVE : KIND_FIND;
			if (tbl_count > 0 && $urandom_range(3) != 0)
				bgn = tbl_begin[$urandom_range(tbl_count - 1)];
		end else begin
			kind = KIND_UNKNOWN;
		end
		send_item(kind, bgn, fin, room, 1'b0, STAT_OK);
	endtask

	initial begin
		#2_000_000;
		$display("sorted_interval_table_test failed");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < NUM_ROWS; r++) begin
			if (directed_rows[r].what == ROW_REG) begin
				wait_idle();
				write_reg(directed_rows[r].bgn[CFG_ADDR_W-1:0], directed_rows[r].fin);
			end else begin
				send_item(directed_rows[r].kind, directed_rows[r].bgn, directed_rows[r].fin,
					directed_rows[r].room, directed_rows[r].typed, directed_rows[r].status);
			end
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_idle();
			write_reg(REG_DAY_BEGIN, CFG_W'(phase_lo[p]));
			write_reg(REG_DAY_END, CFG_W'(phase_hi[p]));
			idle_pct  = phase_idle[p];
			stall_pct = phase_stall[p];
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// long output hold-off while items keep coming
				if (p == 0 && n == 100)
					hold_req = 1'b1;
				random_item(((n / SEGMENT_ITEMS) % 2) == 0);
			end
		end

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && result_q.size() == 0)
			$display("sorted_interval_table_test passed");
		else
			$display("sorted_interval_table_test failed");
		$finish;
	end

endmodule
